// ===== design/rtcswc_pkg.sv =====
// rtcswc_pkg: shared types, constants, the bcd decode functions and a clamp
// for the rtc snapshot wall clock; depends on nothing

package rtcswc_pkg;

    localparam logic ACT_SNAPSHOT = 1'b0;
    localparam logic ACT_TICK     = 1'b1;

    localparam int unsigned SB_BINARY_BIT = 2;
    localparam int unsigned SB_24H_BIT    = 1;
    localparam int unsigned HR_PM_BIT     = 7;

    localparam logic [10:0] MS_PER_SEC     = 11'd1000;
    localparam logic [10:0] MS_TWO_SEC     = 11'd2000;
    localparam logic [6:0]  SEC_PER_MIN    = 7'd60;
    localparam logic [6:0]  MIN_PER_HR     = 7'd60;
    localparam logic [5:0]  HR_PER_DAY     = 6'd24;
    localparam logic [7:0]  SEC_MAX        = 8'd59;
    localparam logic [7:0]  MIN_MAX        = 8'd59;
    localparam logic [7:0]  HR_MAX         = 8'd23;
    localparam logic [6:0]  HR_NOON        = 7'd12;
    localparam logic [7:0]  PM_OFFSET      = 8'd12;
    localparam logic [7:0]  CENTURY        = 8'd20;

    typedef logic [47:0] snapshot_t;

    // low nibble plus ten times high nibble, no digit check
    function automatic logic [7:0] bcd_byte(input logic [7:0] b);
        logic [7:0] tens;
        tens = {4'd0, b[7:4]};
        return {4'd0, b[3:0]} + (tens << 3) + (tens << 1);
    endfunction

    // hours: only bits 6..4 carry the tens digit, bit 7 kept as is
    function automatic logic [7:0] bcd_hour(input logic [7:0] b);
        logic [6:0] tens;
        logic [6:0] sum;
        tens = {4'd0, b[6:4]};
        sum  = {3'd0, b[3:0]} + (tens << 3) + (tens << 1);
        return {b[7], sum};
    endfunction

    function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] top);
        return (v > top) ? top : v;
    endfunction

endpackage

// ===== design/rtc_snapshot_wall_clock.sv =====
// rtc_snapshot_wall_clock: wall clock loaded from rtc snapshot pairs and
// advanced by millisecond ticks; depends on rtcswc_pkg
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_ready | action, raw_* bytes, status_b, update_busy,
//          |                     | elapsed_ms
//  out     | out_valid/out_ready | millis, secs, mins, hrs, day_of_month,
//          |                     | month_num, year_num, time_valid, resync_request
//
// one result per transaction: an input register, then the snapshot decode or the
// tick carry chain into the clock state, which is the result register. a new
// transaction is taken every cycle while out_ready is high; a stalled result holds
// the input register, which takes no more once it is full. reset clears the clock
// (resync requested) and empties both registers.

module rtc_snapshot_wall_clock (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] raw_seconds,
    input  logic [7:0] raw_minutes,
    input  logic [7:0] raw_hours,
    input  logic [7:0] raw_day,
    input  logic [7:0] raw_month,
    input  logic [7:0] raw_year,
    input  logic [7:0] status_b,
    input  logic       update_busy,
    input  logic [9:0] elapsed_ms,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [9:0] millis,
    output logic [5:0] secs,
    output logic [5:0] mins,
    output logic [4:0] hrs,
    output logic [7:0] day_of_month,
    output logic [7:0] month_num,
    output logic [7:0] year_num,
    output logic       time_valid,
    output logic       resync_request
);
    import rtcswc_pkg::*;

    // input register
    logic       s1_valid_reg;
    logic       s1_action_reg;
    snapshot_t  s1_snap_reg;
    logic [7:0] s1_status_b_reg;
    logic       s1_busy_reg;
    logic [9:0] s1_elapsed_reg;

    // clock state
    logic       prev_valid_reg, prev_valid_next;
    snapshot_t  prev_snapshot_reg, prev_snapshot_next;
    logic [9:0] ms_count_reg, ms_count_next;
    logic [5:0] sec_count_reg, sec_count_next;
    logic [5:0] min_count_reg, min_count_next;
    logic [4:0] hour_count_reg, hour_count_next;
    logic [7:0] day_reg, day_next;
    logic [7:0] month_reg, month_next;
    logic [7:0] year_reg, year_next;
    logic       clock_valid_reg, clock_valid_next;

    // result register
    logic       out_valid_reg;

    logic advance;
    logic s1_fire;

    assign advance  = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;

    // snapshot decode
    logic [7:0] raw_s, raw_m, raw_h, raw_d, raw_mo, raw_y;
    logic [7:0] dec_s, dec_m, dec_h, dec_d, dec_mo, dec_y;
    logic [7:0] hr12;
    logic [6:0] hr_low;

    assign {raw_s, raw_m, raw_h, raw_d, raw_mo, raw_y} = s1_snap_reg;

    always_comb
    begin
        if (s1_status_b_reg[SB_BINARY_BIT])
        begin
            dec_s  = raw_s;
            dec_m  = raw_m;
            dec_h  = raw_h;
            dec_d  = raw_d;
            dec_mo = raw_mo;
            dec_y  = raw_y;
        end
        else
        begin
            dec_s  = bcd_byte(raw_s);
            dec_m  = bcd_byte(raw_m);
            dec_h  = bcd_hour(raw_h);
            dec_d  = bcd_byte(raw_d);
            dec_mo = bcd_byte(raw_mo);
            dec_y  = bcd_byte(raw_y);
        end

        // 12-hour: twelve o'clock means hour zero, pm adds twelve
        hr_low = (dec_h[6:0] == HR_NOON) ? 7'd0 : dec_h[6:0];
        if (s1_status_b_reg[SB_24H_BIT])
            hr12 = dec_h;
        else if (dec_h[HR_PM_BIT])
            hr12 = {1'b0, hr_low} + PM_OFFSET;
        else
            hr12 = {1'b0, hr_low};
    end

    // tick carry chain
    logic [10:0] ms_sum, ms_wrap;
    logic [6:0]  s_sum, s_wrap;
    logic [6:0]  m_sum, m_wrap;
    logic [5:0]  h_sum;
    logic [1:0]  sec_carry;
    logic        min_carry, hr_carry;

    always_comb
    begin
        ms_sum = {1'b0, ms_count_reg} + {1'b0, s1_elapsed_reg};
        if (ms_sum >= MS_TWO_SEC)
        begin
            ms_wrap   = ms_sum - MS_TWO_SEC;
            sec_carry = 2'd2;
        end
        else if (ms_sum >= MS_PER_SEC)
        begin
            ms_wrap   = ms_sum - MS_PER_SEC;
            sec_carry = 2'd1;
        end
        else
        begin
            ms_wrap   = ms_sum;
            sec_carry = 2'd0;
        end

        s_sum     = {1'b0, sec_count_reg} + {5'd0, sec_carry};
        min_carry = (s_sum >= SEC_PER_MIN);
        s_wrap    = min_carry ? s_sum - SEC_PER_MIN : s_sum;

        m_sum    = {1'b0, min_count_reg} + {6'd0, min_carry};
        hr_carry = (m_sum >= MIN_PER_HR);
        m_wrap   = hr_carry ? m_sum - MIN_PER_HR : m_sum;

        h_sum = {1'b0, hour_count_reg} + {5'd0, hr_carry};
    end

    // next clock state
    logic [7:0] s_clamp, m_clamp, h_clamp;

    always_comb
    begin
        s_clamp = clamp8(dec_s, SEC_MAX);
        m_clamp = clamp8(dec_m, MIN_MAX);
        h_clamp = clamp8(hr12, HR_MAX);

        prev_valid_next    = prev_valid_reg;
        prev_snapshot_next = prev_snapshot_reg;
        ms_count_next      = ms_count_reg;
        sec_count_next     = sec_count_reg;
        min_count_next     = min_count_reg;
        hour_count_next    = hour_count_reg;
        day_next           = day_reg;
        month_next         = month_reg;
        year_next          = year_reg;
        clock_valid_next   = clock_valid_reg;

        case (s1_action_reg)
            ACT_TICK:
            begin
                if (clock_valid_reg)
                begin
                    ms_count_next  = ms_wrap[9:0];
                    sec_count_next = s_wrap[5:0];
                    min_count_next = m_wrap[5:0];
                    if (h_sum >= HR_PER_DAY)
                    begin
                        // rolled past midnight: freeze and ask for a resync
                        hour_count_next  = HR_PER_DAY[4:0];
                        clock_valid_next = 1'b0;
                        prev_valid_next  = 1'b0;
                    end
                    else
                    begin
                        hour_count_next = h_sum[4:0];
                    end
                end
            end
            ACT_SNAPSHOT:
            begin
                if (!clock_valid_reg && !s1_busy_reg)
                begin
                    if (prev_valid_reg && (s1_snap_reg == prev_snapshot_reg))
                    begin
                        ms_count_next    = '0;
                        sec_count_next   = s_clamp[5:0];
                        min_count_next   = m_clamp[5:0];
                        hour_count_next  = h_clamp[4:0];
                        day_next         = dec_d;
                        month_next       = dec_mo;
                        year_next        = dec_y;
                        clock_valid_next = 1'b1;
                        prev_valid_next  = 1'b0;
                    end
                    else
                    begin
                        prev_snapshot_next = s1_snap_reg;
                        prev_valid_next    = 1'b1;
                    end
                end
            end
            default:
            begin
                clock_valid_next = clock_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_valid_reg    <= 1'b0;
            prev_snapshot_reg <= '0;
            ms_count_reg      <= '0;
            sec_count_reg     <= '0;
            min_count_reg     <= '0;
            hour_count_reg    <= '0;
            day_reg           <= '0;
            month_reg         <= '0;
            year_reg          <= '0;
            clock_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (s1_fire)
            begin
                prev_valid_reg    <= prev_valid_next;
                prev_snapshot_reg <= prev_snapshot_next;
                ms_count_reg      <= ms_count_next;
                sec_count_reg     <= sec_count_next;
                min_count_reg     <= min_count_next;
                hour_count_reg    <= hour_count_next;
                day_reg           <= day_next;
                month_reg         <= month_next;
                year_reg          <= year_next;
                clock_valid_reg   <= clock_valid_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_action_reg   <= action;
            s1_snap_reg     <= {raw_seconds, raw_minutes, raw_hours,
                                raw_day, raw_month, raw_year};
            s1_status_b_reg <= status_b;
            s1_busy_reg     <= update_busy;
            s1_elapsed_reg  <= elapsed_ms;
        end
    end

    // the result is the clock state just written, so outputs read it directly
    assign out_valid      = out_valid_reg;
    assign millis         = ms_count_reg;
    assign secs           = sec_count_reg;
    assign mins           = min_count_reg;
    assign hrs            = hour_count_reg;
    assign day_of_month   = day_reg;
    assign month_num      = month_reg;
    assign year_num       = year_reg;
    assign time_valid     = clock_valid_reg;
    assign resync_request = !clock_valid_reg;

    a_hour_below_24_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        clock_valid_reg |-> (hour_count_reg < HR_PER_DAY[4:0]))
        else $error("hour count at 24 while clock valid");

    a_no_pending_pair_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        clock_valid_reg |-> !prev_valid_reg)
        else $error("snapshot pair pending while clock valid");

    a_ms_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ms_count_reg < MS_PER_SEC[9:0])
        else $error("millisecond count out of range");

    a_load_zeroes_ms: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(clock_valid_reg) |-> (ms_count_reg == 10'd0))
        else $error("clock loaded with nonzero milliseconds");

    a_state_moves_only_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(ms_count_reg) && $stable(clock_valid_reg)
            && $stable(hour_count_reg)))
        else $error("clock state changed while result stalled");

endmodule

// ===== bench/rtc_snapshot_wall_clock_test.sv =====
// rtc_snapshot_wall_clock_test: self-checking bench for the rtc snapshot wall clock
// drives snapshot and tick transactions, predicts every result and compares it
// depends on rtcswc_pkg and rtc_snapshot_wall_clock

module rtc_snapshot_wall_clock_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rtcswc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic       act;
        logic [7:0] sec_b;
        logic [7:0] min_b;
        logic [7:0] hr_b;
        logic [7:0] day_b;
        logic [7:0] mon_b;
        logic [7:0] yr_b;
        logic [7:0] sb;
        logic       busy;
        logic [9:0] elapsed;
    } rtc_item_t;

    typedef struct {
        logic [9:0] millis;
        logic [5:0] secs;
        logic [5:0] mins;
        logic [4:0] hrs;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic       time_ok;
        logic       resync;
    } clock_reading_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       action = ACT_SNAPSHOT;
    logic [7:0] raw_seconds = 8'd0;
    logic [7:0] raw_minutes = 8'd0;
    logic [7:0] raw_hours = 8'd0;
    logic [7:0] raw_day = 8'd0;
    logic [7:0] raw_month = 8'd0;
    logic [7:0] raw_year = 8'd0;
    logic [7:0] status_b = 8'd0;
    logic       update_busy = 1'b0;
    logic [9:0] elapsed_ms = 10'd0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [9:0] millis;
    logic [5:0] secs;
    logic [5:0] mins;
    logic [4:0] hrs;
    logic [7:0] day_of_month;
    logic [7:0] month_num;
    logic [7:0] year_num;
    logic       time_valid;
    logic       resync_request;

    // predicted clock state
    bit          clock_loaded = 1'b0;
    bit          snap_held = 1'b0;
    logic [47:0] held_snapshot = 48'd0;
    int          clk_ms = 0;
    int          clk_sec = 0;
    int          clk_min = 0;
    int          clk_hr = 0;
    logic [7:0]  clk_day = 8'd0;
    logic [7:0]  clk_mon = 8'd0;
    logic [7:0]  clk_yr = 8'd0;
    bit          item_ignored;

    clock_reading_t pending_readings[$];

    bit idle_gaps = 1'b1;
    bit idle_stalls = 1'b1;
    int sink_wait = 0;
    int cycle_count = 0;
    int mismatch_count = 0;
    int checked_count = 0;
    int sent_count = 0;
    int counted_items = 0;
    int load_count = 0;
    int rollover_count = 0;

    rtc_snapshot_wall_clock dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .action(action),
        .raw_seconds(raw_seconds),
        .raw_minutes(raw_minutes),
        .raw_hours(raw_hours),
        .raw_day(raw_day),
        .raw_month(raw_month),
        .raw_year(raw_year),
        .status_b(status_b),
        .update_busy(update_busy),
        .elapsed_ms(elapsed_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .millis(millis),
        .secs(secs),
        .mins(mins),
        .hrs(hrs),
        .day_of_month(day_of_month),
        .month_num(month_num),
        .year_num(year_num),
        .time_valid(time_valid),
        .resync_request(resync_request)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int decode_bcd(input logic [7:0] b);
        return b[3:0] + 10 * b[7:4];
    endfunction

    // decoded and clamped values a matching snapshot would load
    function automatic void decode_snapshot(input rtc_item_t it, output int s, output int m,
                                            output int h, output int d, output int mo,
                                            output int y);
        bit pm;
        s = int'(it.sec_b);
        m = int'(it.min_b);
        h = int'(it.hr_b);
        d = int'(it.day_b);
        mo = int'(it.mon_b);
        y = int'(it.yr_b);
        if (!it.sb[SB_BINARY_BIT])
        begin
            s = decode_bcd(it.sec_b);
            m = decode_bcd(it.min_b);
            h = it.hr_b[3:0] + 10 * it.hr_b[6:4] + (it.hr_b[HR_PM_BIT] ? 128 : 0);
            d = decode_bcd(it.day_b);
            mo = decode_bcd(it.mon_b);
            y = decode_bcd(it.yr_b);
        end
        if (!it.sb[SB_24H_BIT])
        begin
            pm = (h >= 128);
            h = h % 128;
            if (h == HR_NOON)
                h = 0;
            if (pm)
                h += PM_OFFSET;
        end
        if (s > SEC_MAX)
            s = SEC_MAX;
        if (m > MIN_MAX)
            m = MIN_MAX;
        if (h > HR_MAX)
            h = HR_MAX;
    endfunction

    function automatic clock_reading_t next_clock_reading(input rtc_item_t it);
        clock_reading_t r;
        int s, m, h, d, mo, y, ms;
        item_ignored = 1'b0;
        if (it.act == ACT_TICK)
        begin
            if (!clock_loaded)
                item_ignored = 1'b1;
            else
            begin
                ms = clk_ms + int'(it.elapsed);
                s = clk_sec;
                m = clk_min;
                h = clk_hr;
                repeat (2)
                    if (ms >= MS_PER_SEC)
                    begin
                        ms -= MS_PER_SEC;
                        s++;
                    end
                if (s >= SEC_PER_MIN)
                begin
                    s -= SEC_PER_MIN;
                    m++;
                end
                if (m >= MIN_PER_HR)
                begin
                    m -= MIN_PER_HR;
                    h++;
                end
                if (h >= HR_PER_DAY)
                begin
                    h = HR_PER_DAY;
                    clock_loaded = 1'b0;
                    snap_held = 1'b0;
                    rollover_count++;
                end
                clk_ms = ms;
                clk_sec = s;
                clk_min = m;
                clk_hr = h;
            end
        end
        else if (clock_loaded || it.busy)
            item_ignored = 1'b1;
        else if (snap_held && held_snapshot ==
                 {it.sec_b, it.min_b, it.hr_b, it.day_b, it.mon_b, it.yr_b})
        begin
            decode_snapshot(it, s, m, h, d, mo, y);
            clk_ms = 0;
            clk_sec = s;
            clk_min = m;
            clk_hr = h;
            clk_day = d[7:0];
            clk_mon = mo[7:0];
            clk_yr = y[7:0];
            clock_loaded = 1'b1;
            snap_held = 1'b0;
            load_count++;
        end
        else
        begin
            held_snapshot = {it.sec_b, it.min_b, it.hr_b, it.day_b, it.mon_b, it.yr_b};
            snap_held = 1'b1;
        end
        r.millis = clk_ms[9:0];
        r.secs = clk_sec[5:0];
        r.mins = clk_min[5:0];
        r.hrs = clk_hr[4:0];
        r.day = clk_day;
        r.month = clk_mon;
        r.year = clk_yr;
        r.time_ok = clock_loaded;
        r.resync = !clock_loaded;
        return r;
    endfunction

    function automatic rtc_item_t make_snapshot(input logic [7:0] s, input logic [7:0] m,
                                                input logic [7:0] h, input logic [7:0] d,
                                                input logic [7:0] mo, input logic [7:0] y,
                                                input logic [7:0] sb, input logic busy);
        rtc_item_t it;
        it.act = ACT_SNAPSHOT;
        it.sec_b = s;
        it.min_b = m;
        it.hr_b = h;
        it.day_b = d;
        it.mon_b = mo;
        it.yr_b = y;
        it.sb = sb;
        it.busy = busy;
        it.elapsed = 10'($urandom_range(0, 1023));
        return it;
    endfunction

    function automatic rtc_item_t make_tick(input logic [9:0] ms);
        rtc_item_t it;
        it = make_snapshot(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        it.act = ACT_TICK;
        it.elapsed = ms;
        return it;
    endfunction

    function automatic logic [7:0] encode_field(input int v, input bit binary);
        return binary ? 8'(v) : 8'(((v / 10) << 4) + (v % 10));
    endfunction

    // always lands in the last minute before midnight so a few dozen ticks roll it over
    function automatic rtc_item_t random_snapshot(input bit well_formed);
        rtc_item_t it;
        logic [7:0] sb;
        bit bin;
        int s, m, h, d, mo, y;
        sb = 8'($urandom_range(0, 255));
        bin = sb[SB_BINARY_BIT];
        if (well_formed)
        begin
            it = make_snapshot(encode_field($urandom_range(0, 59), bin), encode_field(59, bin),
                               sb[SB_24H_BIT] ? encode_field(23, bin)
                                              : (encode_field(11, bin) | 8'h80),
                               encode_field($urandom_range(1, 31), bin),
                               encode_field($urandom_range(1, 12), bin),
                               encode_field($urandom_range(0, 99), bin), sb, 1'b0);
        end
        else
        begin
            it = make_snapshot(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               sb, 1'b0);
            decode_snapshot(it, s, m, h, d, mo, y);
            while (h != HR_MAX || m != MIN_MAX)
            begin
                it.hr_b = 8'($urandom_range(0, 255));
                it.min_b = 8'($urandom_range(0, 255));
                decode_snapshot(it, s, m, h, d, mo, y);
            end
        end
        return it;
    endfunction

    function automatic logic [9:0] random_elapsed();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return 10'($urandom_range(900, 1023));
        else if (pick < 8)
            return 10'($urandom_range(0, 999));
        else if (pick < 9)
            return 10'($urandom_range(1000, 1023));
        else
            return ($urandom_range(0, 1) != 0) ? 10'd1023 : 10'd0;
    endfunction

    task automatic send_item(input rtc_item_t it);
        int gap;
        gap = idle_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= it.act;
        raw_seconds <= it.sec_b;
        raw_minutes <= it.min_b;
        raw_hours <= it.hr_b;
        raw_day <= it.day_b;
        raw_month <= it.mon_b;
        raw_year <= it.yr_b;
        status_b <= it.sb;
        update_busy <= it.busy;
        elapsed_ms <= it.elapsed;
        do @(posedge clk); while (!in_ready);
        pending_readings.push_back(next_clock_reading(it));
        sent_count++;
        if (!item_ignored)
            counted_items++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
    endtask

    // result checker and receiver stall generator
    always @(posedge clk)
    begin : result_check
        clock_reading_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked_count++;
                if (pending_readings.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (millis !== want.millis)
                    begin
                        $error("millis: expected %0d, got %0d", want.millis, millis);
                        mismatch_count++;
                    end
                    if (secs !== want.secs)
                    begin
                        $error("secs: expected %0d, got %0d", want.secs, secs);
                        mismatch_count++;
                    end
                    if (mins !== want.mins)
                    begin
                        $error("mins: expected %0d, got %0d", want.mins, mins);
                        mismatch_count++;
                    end
                    if (hrs !== want.hrs)
                    begin
                        $error("hrs: expected %0d, got %0d", want.hrs, hrs);
                        mismatch_count++;
                    end
                    if (day_of_month !== want.day)
                    begin
                        $error("day_of_month: expected %0d, got %0d", want.day, day_of_month);
                        mismatch_count++;
                    end
                    if (month_num !== want.month)
                    begin
                        $error("month_num: expected %0d, got %0d", want.month, month_num);
                        mismatch_count++;
                    end
                    if (year_num !== want.year)
                    begin
                        $error("year_num: expected %0d, got %0d", want.year, year_num);
                        mismatch_count++;
                    end
                    if (time_valid !== want.time_ok)
                    begin
                        $error("time_valid: expected %0d, got %0d", want.time_ok, time_valid);
                        mismatch_count++;
                    end
                    if (resync_request !== want.resync)
                    begin
                        $error("resync_request: expected %0d, got %0d", want.resync,
                               resync_request);
                        mismatch_count++;
                    end
                end
                sink_wait = idle_stalls ? $urandom_range(0, 3) : 0;
            end
            else if (sink_wait > 0)
                sink_wait--;
            out_ready <= (sink_wait == 0);
        end
    end

    // nothing loaded yet: ticks and busy snapshots must leave the clock alone
    task automatic test_idle_inputs();
        send_item(make_tick(10'd1023));
        send_item(make_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h02, 1'b1));
    endtask

    // only two equal snapshots in a row load; busy ones are skipped in between
    task automatic test_snapshot_pairing();
        rtc_item_t ref_snap;
        rtc_item_t off_snap;
        ref_snap = make_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h02, 1'b0);
        off_snap = ref_snap;
        off_snap.sec_b = 8'h58;
        send_item(ref_snap);
        send_item(off_snap);
        ref_snap.busy = 1'b1;
        send_item(ref_snap);
        ref_snap.busy = 1'b0;
        send_item(ref_snap);
        send_item(ref_snap);
        // already running, so a fresh snapshot is dropped
        send_item(off_snap);
    endtask

    task automatic test_midnight_rollover();
        send_item(make_tick(10'd999));
        send_item(make_tick(10'd1));
        send_item(make_tick(10'd500));
        hold_until_drained();
    endtask

    // 11 pm in 12-hour bcd, day/month/year bytes decode without a digit check
    task automatic test_12_hour_conversion();
        rtc_item_t pm_snap;
        pm_snap = make_snapshot(8'h59, 8'h59, 8'h91, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_item(pm_snap);
        send_item(pm_snap);
        send_item(make_tick(10'd1023));
    endtask

    // binary 24-hour with every time-field bit set: all three time fields clamp
    task automatic test_binary_clamps();
        rtc_item_t max_snap;
        max_snap = make_snapshot(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0);
        send_item(max_snap);
        send_item(max_snap);
        send_item(make_tick(10'd1023));
    endtask

    task automatic test_random_traffic(input int target);
        rtc_item_t pair_snap;
        rtc_item_t noise;
        int done_at;
        done_at = counted_items + target;
        while (counted_items < done_at || clock_loaded)
        begin
            if (!clock_loaded)
            begin
                idle_gaps = ($urandom_range(0, 3) != 0);
                idle_stalls = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) == 0)
                    hold_until_drained();
                case ($urandom_range(0, 9))
                    0: send_item(make_tick(random_elapsed()));
                    1:
                    begin
                        noise = random_snapshot(1'b0);
                        noise.busy = 1'($urandom_range(0, 1));
                        send_item(noise);
                    end
                    default:
                    begin
                        pair_snap = random_snapshot($urandom_range(0, 3) != 0);
                        send_item(pair_snap);
                        if ($urandom_range(0, 7) == 0)
                        begin
                            noise = random_snapshot(1'b0);
                            noise.busy = 1'b1;
                            send_item(noise);
                        end
                        // broken pair: second read differs
                        if ($urandom_range(0, 9) == 0)
                            pair_snap.sec_b ^= 8'h01;
                        send_item(pair_snap);
                    end
                endcase
            end
            else if ($urandom_range(0, 19) == 0)
                send_item(random_snapshot($urandom_range(0, 1) != 0));
            else
                send_item(make_tick(random_elapsed()));
        end
    endtask

    // 12 am in 12-hour bcd reads as hour 0; double carry then runs into the hour
    task automatic test_noon_midnight_carry();
        rtc_item_t am_snap;
        idle_gaps = 1'b1;
        idle_stalls = 1'b1;
        am_snap = make_snapshot(8'h59, 8'h59, 8'h12, 8'h01, 8'h01, 8'h00, 8'h00, 1'b0);
        send_item(am_snap);
        send_item(am_snap);
        send_item(make_tick(10'd999));
        send_item(make_tick(10'd1023));
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_inputs();
        test_snapshot_pairing();
        test_midnight_rollover();
        test_12_hour_conversion();
        test_binary_clamps();
        test_random_traffic(1500);
        test_noon_midnight_carry();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_readings.size() != 0);
        repeat (8) @(posedge clk);
        $display("sent %0d transactions (%0d not ignored), %0d clock loads,",
                 sent_count, counted_items, load_count);
        $display("%0d midnight rollovers, checked %0d results, %0d mismatches",
                 rollover_count, checked_count, mismatch_count);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rtcswc_pkg.sv
design/rtc_snapshot_wall_clock.sv
bench/rtc_snapshot_wall_clock_test.sv
